>>> hdl/adt_pkg.sv
// ----------------------------------------------------------------------------
// adt_pkg
// Shared constants, types and helpers of the alien dictionary order finder.
// ----------------------------------------------------------------------------
package adt_pkg;

  localparam int ALPHABET     = 26;
  localparam int MAX_WORD_LEN = 32;
  localparam int LETTER_W     = 5;
  localparam int NODE_W       = $clog2(ALPHABET);
  localparam int CNT_W        = $clog2(ALPHABET + 1);
  localparam int POS_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int ADDR_W       = $clog2(MAX_WORD_LEN);

  typedef enum logic [1:0] {
    S_LOAD,
    S_DRAIN,
    S_WALK,
    S_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_ROOT,
    W_LOAD,
    W_SCAN,
    W_POP,
    W_DONE
  } walk_state_e;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] from;
    logic [NODE_W-1:0] to;
  } edge_wr_t;

  typedef struct packed {
    logic start;
    logic clear;
  } walk_ctl_t;

  typedef struct packed {
    logic done;
    logic cycle;
  } walk_sts_t;

  // index of the lowest set bit, zero when none
  function automatic logic [NODE_W-1:0] lowest_idx(input logic [ALPHABET-1:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = ALPHABET - 1; i >= 0; i--) begin
      if (v[i]) r = NODE_W'(i);
    end
    return r;
  endfunction

endpackage

>>> hdl/alien_dictionary_topo_sort.sv
// Letters are taken one per cycle while in_stall_o is low; a letter item gives no result.
// On a list end: a drain state, then the walk, bounded by edge-row reads.
// Results then leave one per cycle, unless out_stall_i holds them, from the finish-order store: 26, or one.
// rst_ni clears all control state asynchronously; no clearing pass is needed.
// ----------------------------------------------------------------------------
// alien_dictionary_topo_sort
// Loads the sorted word list, records first-difference edges and emits the
// reversed depth-first finish order of the alphabet.
// ----------------------------------------------------------------------------
module alien_dictionary_topo_sort (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [adt_pkg::LETTER_W-1:0] letter_i,
  input  logic                        word_end_i,
  input  logic                        list_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [adt_pkg::LETTER_W-1:0] out_letter_o,
  output logic                        has_cycle_o,
  output logic                        last_result_o
);
  import adt_pkg::*;

  logic [LETTER_W-1:0] prev_mem [MAX_WORD_LEN];

  top_state_e          state_q, state_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    prev_len_q, prev_len_d;
  logic                have_prev_q, have_prev_d;
  logic                diff_q, diff_d;

  logic                b_valid_q;
  logic [LETTER_W-1:0] b_letter_q;
  logic [ADDR_W-1:0]   b_pos_q;
  logic                b_wr_q, b_cmp_q, b_end_q;
  logic [LETTER_W-1:0] prev_rd_q;
  logic                fwd_q;
  logic [LETTER_W-1:0] fwd_data_q;

  logic                out_valid_q;
  logic [LETTER_W-1:0] out_letter_q;
  logic                has_cycle_q, last_result_q;
  logic [NODE_W-1:0]   emit_q, emit_d;

  logic                accept;
  logic                in_range;
  logic [POS_W-1:0]    pos_inc;
  logic [LETTER_W-1:0] prev_letter;
  logic                found;
  logic                out_free;
  logic                out_load;
  logic [LETTER_W-1:0] out_letter_d;
  logic                has_cycle_d, last_result_d;

  edge_wr_t            edge_wr;
  walk_ctl_t           walk_ctl;
  walk_sts_t           walk_sts;
  logic                fin_re;
  logic [NODE_W-1:0]   fin_raddr;
  logic [NODE_W-1:0]   fin_rdata;

  assign in_stall_o = (state_q != S_LOAD);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (pos_q < POS_W'(MAX_WORD_LEN));
  assign pos_inc    = in_range ? pos_q + POS_W'(1) : pos_q;

  // stage A: read the previous word's letter at this position
  always_ff @(posedge clk_i) begin
    if (accept && in_range) prev_rd_q <= prev_mem[pos_q[ADDR_W-1:0]];
    if (b_valid_q && b_wr_q) prev_mem[b_pos_q] <= b_letter_q;
    if (accept) begin
      fwd_q      <= b_valid_q && b_wr_q && (b_pos_q == pos_q[ADDR_W-1:0]);
      fwd_data_q <= b_letter_q;
      b_letter_q <= letter_i;
      b_pos_q    <= pos_q[ADDR_W-1:0];
      b_wr_q     <= in_range;
      b_cmp_q    <= in_range && have_prev_q && (pos_q < prev_len_q);
      b_end_q    <= word_end_i || list_end_i;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    prev_len_d  = prev_len_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      pos_d = pos_inc;
      if (word_end_i || list_end_i) begin
        prev_len_d  = pos_inc;
        pos_d       = '0;
        have_prev_d = 1'b1;
      end
      if (list_end_i) begin
        prev_len_d  = '0;
        have_prev_d = 1'b0;
      end
    end
  end

  // stage B: compare, record the edge
  assign prev_letter = fwd_q ? fwd_data_q : prev_rd_q;
  assign found       = b_valid_q && b_cmp_q && !diff_q && (prev_letter != b_letter_q);
  assign edge_wr.en  = found && (prev_letter < LETTER_W'(ALPHABET))
                       && (b_letter_q < LETTER_W'(ALPHABET));
  assign edge_wr.from = NODE_W'(prev_letter);
  assign edge_wr.to   = NODE_W'(b_letter_q);

  always_comb begin
    diff_d = diff_q;
    if (b_valid_q) diff_d = b_end_q ? 1'b0 : (diff_q || found);
  end

  adt_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .edge_wr_i   (edge_wr),
    .ctl_i       (walk_ctl),
    .sts_o       (walk_sts),
    .fin_re_i    (fin_re),
    .fin_raddr_i (fin_raddr),
    .fin_rdata_o (fin_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    emit_d         = emit_q;
    walk_ctl.start = 1'b0;
    walk_ctl.clear = 1'b0;
    fin_re         = 1'b0;
    fin_raddr      = NODE_W'(ALPHABET - 1);
    out_load       = 1'b0;
    out_letter_d   = '0;
    has_cycle_d    = 1'b0;
    last_result_d  = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (accept && list_end_i) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        walk_ctl.start = 1'b1;
        state_d        = S_WALK;
      end
      S_WALK: begin
        if (walk_sts.done) begin
          if (walk_sts.cycle) begin
            if (out_free) begin
              out_load       = 1'b1;
              has_cycle_d    = 1'b1;
              last_result_d  = 1'b1;
              walk_ctl.clear = 1'b1;
              state_d        = S_LOAD;
            end
          end else begin
            fin_re  = 1'b1;
            emit_d  = '0;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_letter_d  = LETTER_W'(fin_rdata);
          last_result_d = (emit_q == NODE_W'(ALPHABET - 1));
          if (last_result_d) begin
            walk_ctl.clear = 1'b1;
            state_d        = S_LOAD;
          end else begin
            // advance to the next earlier finisher
            emit_d    = emit_q + NODE_W'(1);
            fin_re    = 1'b1;
            fin_raddr = NODE_W'(ALPHABET - 1) - emit_d;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      pos_q       <= '0;
      prev_len_q  <= '0;
      have_prev_q <= 1'b0;
      diff_q      <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      prev_len_q  <= prev_len_d;
      have_prev_q <= have_prev_d;
      diff_q      <= diff_d;
      b_valid_q   <= accept;
      emit_q      <= emit_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_letter_q  <= out_letter_d;
      has_cycle_q   <= has_cycle_d;
      last_result_q <= last_result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_letter_o  = out_letter_q;
  assign has_cycle_o   = has_cycle_q;
  assign last_result_o = last_result_q;

`ifndef SYNTHESIS
  a_cycle_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_cycle_o) |-> (last_result_o && out_letter_o == '0))
    else $error("cycle result is not a lone final word");
  a_drain_then_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (!b_valid_q || b_end_q) ##1 (state_q == S_WALK))
    else $error("walk started before the last letter settled");
  a_accept_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && list_end_i) |=> (b_valid_q && b_end_q && state_q == S_DRAIN))
    else $error("list end not carried into the compare stage");
`endif

endmodule

>>> hdl/adt_walk.sv
// ----------------------------------------------------------------------------
// adt_walk
// Edge matrix store and depth-first walk sequencer with post-order record.
// ----------------------------------------------------------------------------
module adt_walk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  adt_pkg::edge_wr_t         edge_wr_i,
  input  adt_pkg::walk_ctl_t        ctl_i,
  output adt_pkg::walk_sts_t        sts_o,
  input  logic                      fin_re_i,
  input  logic [adt_pkg::NODE_W-1:0] fin_raddr_i,
  output logic [adt_pkg::NODE_W-1:0] fin_rdata_o
);
  import adt_pkg::*;

  logic [ALPHABET-1:0] edge_mem [ALPHABET];
  logic [NODE_W-1:0]   stk_mem  [ALPHABET];
  logic [NODE_W-1:0]   fin_mem  [ALPHABET];

  logic [ALPHABET-1:0] row_vld_q;
  logic [ALPHABET-1:0] row_rdata_q;
  logic                row_rvld_q;
  logic [NODE_W-1:0]   stk_rdata_q;
  logic [NODE_W-1:0]   fin_rdata_q;

  walk_state_e         state_q, state_d;
  logic [NODE_W-1:0]   node_q, node_d;
  logic [ALPHABET-1:0] row_q, row_d;
  logic [ALPHABET-1:0] visited_q, visited_d;
  logic [ALPHABET-1:0] fin_q, fin_d;
  logic                cyc_q, cyc_d;
  logic [CNT_W-1:0]    fcnt_q, fcnt_d;
  logic [NODE_W-1:0]   depth_q, depth_d;

  logic                row_re;
  logic [NODE_W-1:0]   row_raddr;
  logic                stk_we, stk_re;
  logic [NODE_W-1:0]   stk_waddr, stk_raddr;
  logic                fin_we;
  logic [ALPHABET-1:0] cand;
  logic [NODE_W-1:0]   pick;
  logic [ALPHABET-1:0] node_bit;
  logic [ALPHABET-1:0] to_bit;

  assign to_bit = ALPHABET'(1) << edge_wr_i.to;

  // bit-enabled write: an untouched row is rewritten whole
  always_ff @(posedge clk_i) begin
    if (edge_wr_i.en) begin
      for (int j = 0; j < ALPHABET; j++) begin
        if (to_bit[j] || !row_vld_q[edge_wr_i.from]) edge_mem[edge_wr_i.from][j] <= to_bit[j];
      end
    end
    if (row_re) begin
      row_rdata_q <= edge_mem[row_raddr];
      row_rvld_q  <= row_vld_q[row_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (ctl_i.clear) begin
      row_vld_q <= '0;
    end else if (edge_wr_i.en) begin
      row_vld_q[edge_wr_i.from] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= node_q;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
    if (fin_we) fin_mem[fcnt_q[NODE_W-1:0]] <= node_q;
    if (fin_re_i) fin_rdata_q <= fin_mem[fin_raddr_i];
  end

  assign fin_rdata_o = fin_rdata_q;
  assign cand        = row_q & ~visited_q;
  assign pick        = lowest_idx(cand);
  assign node_bit    = ALPHABET'(1) << node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      node_q    <= '0;
      row_q     <= '0;
      visited_q <= '0;
      fin_q     <= '0;
      cyc_q     <= 1'b0;
      fcnt_q    <= '0;
      depth_q   <= '0;
    end else begin
      state_q   <= state_d;
      node_q    <= node_d;
      row_q     <= row_d;
      visited_q <= visited_d;
      fin_q     <= fin_d;
      cyc_q     <= cyc_d;
      fcnt_q    <= fcnt_d;
      depth_q   <= depth_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    node_d    = node_q;
    row_d     = row_q;
    visited_d = visited_q;
    fin_d     = fin_q;
    cyc_d     = cyc_q;
    fcnt_d    = fcnt_q;
    depth_d   = depth_q;
    row_re    = 1'b0;
    row_raddr = node_q;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = depth_q;
    stk_raddr = depth_q - NODE_W'(1);
    fin_we    = 1'b0;
    unique case (state_q)
      W_IDLE: begin
        if (ctl_i.start) begin
          visited_d = '0;
          fin_d     = '0;
          cyc_d     = 1'b0;
          fcnt_d    = '0;
          depth_d   = '0;
          state_d   = W_ROOT;
        end
      end
      W_ROOT: begin
        if (&visited_q) begin
          state_d = W_DONE;
        end else begin
          node_d    = lowest_idx(~visited_q);
          visited_d = visited_q | (ALPHABET'(1) << node_d);
          row_re    = 1'b1;
          row_raddr = node_d;
          state_d   = W_LOAD;
        end
      end
      W_LOAD: begin
        row_d   = row_rvld_q ? row_rdata_q : '0;
        state_d = W_SCAN;
      end
      W_SCAN: begin
        if (|cand) begin
          // descend: park the current node on the stack
          stk_we    = 1'b1;
          depth_d   = depth_q + NODE_W'(1);
          visited_d = visited_q | (ALPHABET'(1) << pick);
          node_d    = pick;
          row_re    = 1'b1;
          row_raddr = pick;
          state_d   = W_LOAD;
        end else begin
          // an edge to a node not yet finished points backwards in the order
          cyc_d  = cyc_q | (|(row_q & ~fin_q & ~node_bit));
          fin_d  = fin_q | node_bit;
          fin_we = 1'b1;
          fcnt_d = fcnt_q + CNT_W'(1);
          if (depth_q == '0) begin
            state_d = W_ROOT;
          end else begin
            stk_re  = 1'b1;
            depth_d = depth_q - NODE_W'(1);
            state_d = W_POP;
          end
        end
      end
      W_POP: begin
        node_d    = stk_rdata_q;
        row_re    = 1'b1;
        row_raddr = stk_rdata_q;
        state_d   = W_LOAD;
      end
      W_DONE: begin
        if (ctl_i.clear) state_d = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  assign sts_o.done  = (state_q == W_DONE);
  assign sts_o.cycle = cyc_q;

`ifndef SYNTHESIS
  a_done_all_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_DONE) |-> (&fin_q && fcnt_q == CNT_W'(ALPHABET)))
    else $error("walk ended with unfinished nodes");
  a_finish_sub_visit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != W_IDLE) |-> ((fin_q & ~visited_q) == '0))
    else $error("node finished before being visited");
  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_SCAN && (|cand)) |=> (state_q == W_LOAD && visited_q[node_q]))
    else $error("descent did not mark the new node");
`endif

endmodule

>>> tb/sv/alien_dictionary_topo_sort_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alien_dictionary_topo_sort_tb
// Feeds sorted word lists letter by letter, predicts the edge matrix and the
// depth-first finish order, and checks every emitted letter and cycle flag.
// ----------------------------------------------------------------------------
module alien_dictionary_topo_sort_tb;
  import adt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                cycle;
    logic                last;
  } order_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [LETTER_W-1:0] letter_i = '0;
  logic                word_end_i = 1'b0;
  logic                list_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LETTER_W-1:0] out_letter_o;
  logic                has_cycle_o;
  logic                last_result_o;

  alien_dictionary_topo_sort dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // predictor state
  logic [LETTER_W-1:0] prev_word [MAX_WORD_LEN];
  int                  prev_len, pos;
  bit                  diff_seen, have_prev;
  logic [ALPHABET-1:0] adj [ALPHABET];
  order_word_t         order_q[$];
  int                  errors, n_items, n_lists, n_cycles, n_results;
  int                  idle_cycles;
  int                  burst_left, gap_left;
  bit                  no_idle;
  int unsigned         tick = 0;

  function automatic bit edge_set(int f, int t);
    if (f >= ALPHABET || t >= ALPHABET) return 1'b0;
    return adj[f][t];
  endfunction

  task automatic clear_predictor();
    prev_len = 0; pos = 0; diff_seen = 0; have_prev = 0;
    for (int i = 0; i < ALPHABET; i++) adj[i] = '0;
  endtask

  // depth-first walk over the adjacency matrix, queueing the expected words
  task automatic predict_order();
    int fin [ALPHABET];
    int stk_node [ALPHABET];
    int stk_next [ALPHABET];
    logic [ALPHABET-1:0] seen;
    int nfin, depth, top, nd, t;
    bit pushed, cyc;
    order_word_t w;
    seen = '0; nfin = 0;
    for (int r = 0; r < ALPHABET; r++) begin
      if (!seen[r]) begin
        seen[r] = 1'b1; stk_node[0] = r; stk_next[0] = 0; depth = 1;
        while (depth > 0) begin
          top = depth - 1; nd = stk_node[top]; t = stk_next[top]; pushed = 0;
          while (t < ALPHABET && !pushed) begin
            if (edge_set(nd, t) && !seen[t]) begin
              stk_next[top] = t + 1; seen[t] = 1'b1;
              if (depth < ALPHABET) begin
                stk_node[depth] = t; stk_next[depth] = 0; depth++;
              end
              pushed = 1;
            end else t++;
          end
          if (!pushed) begin
            stk_next[top] = ALPHABET;
            if (nfin < ALPHABET) begin fin[nfin] = nd; nfin++; end
            depth--;
          end
        end
      end
    end
    cyc = 0;
    for (int i = 0; i < ALPHABET; i++)
      for (int j = i + 1; j < ALPHABET; j++)
        if (edge_set(fin[ALPHABET-1-j], fin[ALPHABET-1-i])) cyc = 1;
    if (cyc) begin
      w.letter = '0; w.cycle = 1'b1; w.last = 1'b1;
      order_q.insert(order_q.size(), w); n_cycles++;
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        w.letter = LETTER_W'(fin[ALPHABET-1-i]); w.cycle = 1'b0;
        w.last = (i == ALPHABET - 1);
        order_q.insert(order_q.size(), w);
      end
    end
  endtask

  task automatic absorb_letter(logic [LETTER_W-1:0] l, bit we, bit le);
    if (pos < MAX_WORD_LEN) begin
      if (have_prev && !diff_seen && pos < prev_len && prev_word[pos] != l) begin
        diff_seen = 1;
        if (prev_word[pos] < ALPHABET && l < ALPHABET) adj[prev_word[pos]][l] = 1'b1;
      end
      prev_word[pos] = l;
      pos++;
    end
    if (we || le) begin
      prev_len = pos; pos = 0; diff_seen = 0; have_prev = 1;
    end
    if (le) begin
      predict_order();
      clear_predictor();
      n_lists++;
    end
  endtask

  // send one letter word; bursts and gaps unless idling is switched off
  task automatic send_letter(logic [LETTER_W-1:0] l, bit we, bit le);
    if (!no_idle) begin
      if (burst_left == 0) begin
        gap_left = $urandom_range(0, 4);
        burst_left = $urandom_range(1, 12);
      end
      while (gap_left > 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        gap_left--;
      end
      burst_left--;
    end
    in_valid_i <= 1'b1; letter_i <= l; word_end_i <= we; list_end_i <= le;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_letter(l, we, le);
    n_items++;
  endtask

  task automatic send_word(int ltr [$], bit le);
    for (int i = 0; i < ltr.size(); i++)
      send_letter(LETTER_W'(ltr[i]), i == ltr.size() - 1, le && i == ltr.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    order_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (order_q.size() == 0) begin
        $display("%0t: unexpected result letter=%0d cycle=%0b last=%0b", $time,
                 out_letter_o, has_cycle_o, last_result_o);
        errors++;
      end else begin
        w = order_q.pop_front();
        if (out_letter_o !== w.letter) begin
          $display("%0t: letter expected %0d actual %0d", $time, w.letter, out_letter_o);
          errors++;
        end
        if (has_cycle_o !== w.cycle) begin
          $display("%0t: has_cycle expected %0b actual %0b", $time, w.cycle, has_cycle_o);
          errors++;
        end
        if (last_result_o !== w.last) begin
          $display("%0t: last expected %0b actual %0b", $time, w.last, last_result_o);
          errors++;
        end
      end
    end
    tick <= tick + 1;
    out_stall_i <= no_idle ? 1'b0 : (($urandom_range(0, 7) < 3) && tick[3]);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed_order();
    // a<b<c chain, a z<a<b chain, then the edgeless single-word list default order
    send_word('{0}, 0); send_word('{1}, 0); send_word('{2}, 1);
    send_word('{25, 0}, 0); send_word('{25, 1}, 0); send_word('{0, 25}, 1);
    send_word('{5}, 1);
  endtask

  task automatic test_directed_specials();
    int longw [$];
    // cycle: a before b, then b before a
    send_word('{0}, 0); send_word('{1}, 0); send_word('{0}, 1);
    // letters outside the alphabet are compared but leave no edge
    send_word('{31, 2}, 0); send_word('{30}, 0); send_word('{26, 3}, 1);
    // overlong word saturates at the maximum length
    longw = {};
    for (int i = 0; i < MAX_WORD_LEN + 3; i++) longw.insert(longw.size(), i % 26);
    send_word(longw, 0);
    longw[MAX_WORD_LEN+1] = 7;
    send_word(longw, 0);
    // list end without word end
    send_letter(LETTER_W'(4), 1'b0, 1'b1);
  endtask

  task automatic test_pause_for_results();
    send_word('{3}, 0); send_word('{9}, 1);
    wait_drained();
    no_idle = 1;
    send_word('{1, 2}, 0); send_word('{1, 4}, 1);
    wait_drained();
    no_idle = 0;
  endtask

  task automatic test_random_lists(int target);
    int w [$];
    int nwords, len, base;
    while (n_items < target) begin
      nwords = $urandom_range(1, 8);
      base = $urandom_range(0, 24);
      for (int k = 0; k < nwords; k++) begin
        w = {};
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) w.insert(w.size(), $urandom_range(0, 31));
          else if ($urandom_range(0, 3) == 0) w.insert(w.size(), $urandom_range(0, 25));
          else w.insert(w.size(), (base + $urandom_range(0, 3)) % 26);
        end
        if ($urandom_range(0, 9) == 0 && k == nwords - 1) begin
          for (int i = 0; i < len; i++)
            send_letter(LETTER_W'(w[i]), 1'b0, i == len - 1);
        end else send_word(w, k == nwords - 1);
      end
    end
  endtask

  initial begin
    int wait_cnt;
    errors = 0; n_items = 0; n_lists = 0; n_cycles = 0; n_results = 0;
    idle_cycles = 0; burst_left = 0; gap_left = 0; no_idle = 0;
    clear_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_order();
    test_directed_specials();
    test_pause_for_results();
    test_random_lists(470);
    in_valid_i <= 1'b0;
    wait_cnt = 0;
    while (order_q.size() != 0 && wait_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (200) @(posedge clk_i);
    if (order_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, order_q.size());
      errors++;
    end
    $display("Sent %0d letters in %0d lists; checked %0d results, %0d cycle verdicts.",
             n_items, n_lists, n_results, n_cycles);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
